// ===== sv/point_segment_distance_hit_test_macros.svh =====
// ---------------------------------------------------------------------------
// point_segment_distance_hit_test_macros
// assertion helpers shared by the distance hit test rtl
// ---------------------------------------------------------------------------
`ifndef POINT_SEGMENT_DISTANCE_HIT_TEST_MACROS_SVH
`define POINT_SEGMENT_DISTANCE_HIT_TEST_MACROS_SVH

`ifndef NO_ASSERTIONS
`define PSD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define PSD_ASSERT_DELAY(label, clk, rst, ante, dly, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error("assertion failed");
`else
`define PSD_ASSERT_IMPL(label, clk, rst, ante, cons)
`define PSD_ASSERT_DELAY(label, clk, rst, ante, dly, cons)
`endif

`endif

// ===== sv/psd_pkg.sv =====
// ---------------------------------------------------------------------------
// psd_pkg
// shared constants for the point to segment distance hit test
// ---------------------------------------------------------------------------
`default_nettype none
package psd_pkg;
   localparam int COORD_BITS_DEF = 14;
   localparam int DIST_BITS      = 15;
   localparam int THRESH_BITS    = 8;
   localparam logic [THRESH_BITS-1:0] THRESH_RESET = 8'd3;
   localparam logic [DIST_BITS-1:0]   DIST_MAX     = 15'h7fff;
endpackage
`default_nettype wire

// ===== sv/psd_div_cell.sv =====
// ---------------------------------------------------------------------------
// psd_div_cell
// one quotient bit of the restoring divide, registered toward the next cell
// ---------------------------------------------------------------------------
`default_nettype none
module psd_div_cell #(
   parameter int CW = 29
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          valid_i,
   input  wire logic [CW-1:0] rem_i,
   input  wire logic [CW-1:0] acc_i,
   input  wire logic [CW-1:0] len2_i,
   input  wire logic [CW-1:0] nend_i,
   input  wire logic          perp_i,
   output logic               valid_o,
   output logic [CW-1:0]      rem_o,
   output logic [CW-1:0]      acc_o,
   output logic [CW-1:0]      len2_o,
   output logic [CW-1:0]      nend_o,
   output logic               perp_o
);
   logic [CW:0]   trial;
   logic [CW:0]   diff;
   logic          take;
   logic          valid_ff;
   logic [CW-1:0] rem_ff, rem_in, acc_ff, acc_in, len2_ff, nend_ff;
   logic          perp_ff;

   always_comb begin
      trial  = {rem_i, acc_i[CW-1]};
      diff   = trial - {1'b0, len2_i};
      take   = trial >= {1'b0, len2_i};
      rem_in = take ? diff[CW-1:0] : trial[CW-1:0];
      acc_in = {acc_i[CW-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_i;
      end
      rem_ff  <= rem_in;
      acc_ff  <= acc_in;
      len2_ff <= len2_i;
      nend_ff <= nend_i;
      perp_ff <= perp_i;
   end

   assign valid_o = valid_ff;
   assign rem_o   = rem_ff;
   assign acc_o   = acc_ff;
   assign len2_o  = len2_ff;
   assign nend_o  = nend_ff;
   assign perp_o  = perp_ff;
endmodule
`default_nettype wire

// ===== sv/psd_sqrt_cell.sv =====
// ---------------------------------------------------------------------------
// psd_sqrt_cell
// one root bit of the digit by digit square root
// ---------------------------------------------------------------------------
`default_nettype none
module psd_sqrt_cell #(
   parameter int RW  = 31,
   parameter int R   = 15,
   parameter int BIT = 0
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          valid_i,
   input  wire logic [RW-1:0] rem_i,
   input  wire logic [R-1:0]  root_i,
   output logic               valid_o,
   output logic [RW-1:0]      rem_o,
   output logic [R-1:0]       root_o
);
   logic [RW-1:0] trial;
   logic          take;
   logic          valid_ff;
   logic [RW-1:0] rem_ff, rem_in;
   logic [R-1:0]  root_ff, root_in;

   // (root + 2^b)^2 - root^2
   always_comb begin
      trial   = (RW'(root_i) << (BIT + 1)) + (RW'(1) << (2 * BIT));
      take    = rem_i >= trial;
      rem_in  = take ? rem_i - trial : rem_i;
      root_in = take ? (root_i | (R'(1) << BIT)) : root_i;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_i;
      end
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign valid_o = valid_ff;
   assign rem_o   = rem_ff;
   assign root_o  = root_ff;
endmodule
`default_nettype wire

// ===== sv/point_segment_distance_hit_test.sv =====
// ---------------------------------------------------------------------------
// point_segment_distance_hit_test
// pipelined truncated distance from a point to a segment with threshold hit
// ---------------------------------------------------------------------------
//  channel   ports                         handshake
//  request   req_point_*, req_seg_*        start & !busy
//  response  rsp_distance, rsp_hit         rsp_valid, one cycle
//  csr       csr_data (hit threshold)      csr_valid & csr_ready
//
// one query per cycle; each passes through five setup stages, one divide cell
// per quotient bit, one select stage, one root cell per distance bit and the
// output register.
// busy stays low; reset clears only the valid chain and the threshold.
// results cannot be stalled, so nothing holds back the pipe.
`default_nettype none
`include "point_segment_distance_hit_test_macros.svh"
module point_segment_distance_hit_test #(
   parameter int COORD_BITS = psd_pkg::COORD_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic signed [COORD_BITS-1:0] req_point_x,
   input  wire logic signed [COORD_BITS-1:0] req_point_y,
   input  wire logic signed [COORD_BITS-1:0] req_seg_ax,
   input  wire logic signed [COORD_BITS-1:0] req_seg_ay,
   input  wire logic signed [COORD_BITS-1:0] req_seg_bx,
   input  wire logic signed [COORD_BITS-1:0] req_seg_by,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [psd_pkg::THRESH_BITS-1:0] csr_data,
   output logic                              rsp_valid,
   output logic [psd_pkg::DIST_BITS-1:0]     rsp_distance,
   output logic                              rsp_hit
);
   localparam int D   = COORD_BITS;
   localparam int DW  = D + 1;
   localparam int PW  = 2 * D + 2;
   localparam int SW  = 2 * D + 3;
   localparam int CW  = 2 * D + 1;
   localparam int H   = D + 1;
   localparam int HW  = CW - H;
   localparam int NW  = 4 * D + 2;
   localparam int K   = CW;
   localparam int R   = D + 1;
   localparam int RW  = 2 * D + 3;
   localparam int MW  = (R > psd_pkg::DIST_BITS) ? R : psd_pkg::DIST_BITS;
   localparam int LAT = K + R + 7;

   logic [psd_pkg::THRESH_BITS-1:0] thresh_ff;
   logic accept;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= psd_pkg::THRESH_RESET;
      end else if (csr_valid && csr_ready) begin
         thresh_ff <= csr_data;
      end
   end

   // stage 0: differences
   logic v0_ff;
   logic signed [DW-1:0] dx_ff, dy_ff, rx_ff, ry_ff, ex_ff, ey_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= accept;
      end
      dx_ff <= DW'(req_seg_bx) - DW'(req_seg_ax);
      dy_ff <= DW'(req_seg_by) - DW'(req_seg_ay);
      rx_ff <= DW'(req_point_x) - DW'(req_seg_ax);
      ry_ff <= DW'(req_point_y) - DW'(req_seg_ay);
      ex_ff <= DW'(req_point_x) - DW'(req_seg_bx);
      ey_ff <= DW'(req_point_y) - DW'(req_seg_by);
   end

   // stage 1: products
   logic v1_ff;
   logic signed [PW-1:0] rxdx_ff, rydy_ff, dxdx_ff, dydy_ff, rxdy_ff, rydx_ff;
   logic signed [PW-1:0] rxrx_ff, ryry_ff, exex_ff, eyey_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v0_ff;
      end
      rxdx_ff <= PW'(rx_ff) * PW'(dx_ff);
      rydy_ff <= PW'(ry_ff) * PW'(dy_ff);
      dxdx_ff <= PW'(dx_ff) * PW'(dx_ff);
      dydy_ff <= PW'(dy_ff) * PW'(dy_ff);
      rxdy_ff <= PW'(rx_ff) * PW'(dy_ff);
      rydx_ff <= PW'(ry_ff) * PW'(dx_ff);
      rxrx_ff <= PW'(rx_ff) * PW'(rx_ff);
      ryry_ff <= PW'(ry_ff) * PW'(ry_ff);
      exex_ff <= PW'(ex_ff) * PW'(ex_ff);
      eyey_ff <= PW'(ey_ff) * PW'(ey_ff);
   end

   // stage 2: sums and region select
   logic signed [SW-1:0] dot, len2s, cross_p, cabs_s, na_s, nb_s;
   logic degen, before_a, past_b;
   always_comb begin
      dot      = SW'(rxdx_ff) + SW'(rydy_ff);
      len2s    = SW'(dxdx_ff) + SW'(dydy_ff);
      cross_p  = SW'(rxdy_ff) - SW'(rydx_ff);
      cabs_s   = cross_p[SW-1] ? -cross_p : cross_p;
      na_s     = SW'(rxrx_ff) + SW'(ryry_ff);
      nb_s     = SW'(exex_ff) + SW'(eyey_ff);
      degen    = len2s == '0;
      before_a = dot[SW-1];
      past_b   = dot > len2s;
   end

   logic v2_ff, perp2_ff;
   logic [CW-1:0] len2_2_ff, cabs_2_ff, nend_2_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      perp2_ff  <= !degen && !before_a && !past_b;
      len2_2_ff <= len2s[CW-1:0];
      cabs_2_ff <= cabs_s[CW-1:0];
      nend_2_ff <= (!degen && !before_a && past_b) ? nb_s[CW-1:0] : na_s[CW-1:0];
   end

   // stage 3: partial products of cross squared
   logic v3_ff, perp3_ff;
   logic [CW-1:0] len2_3_ff, nend_3_ff;
   logic [2*H-1:0]  ll_ff;
   logic [H+HW-1:0] lh_ff;
   logic [2*HW-1:0] hh_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      perp3_ff  <= perp2_ff;
      len2_3_ff <= len2_2_ff;
      nend_3_ff <= nend_2_ff;
      ll_ff <= (2*H)'(cabs_2_ff[H-1:0]) * (2*H)'(cabs_2_ff[H-1:0]);
      lh_ff <= (H+HW)'(cabs_2_ff[H-1:0]) * (H+HW)'(cabs_2_ff[CW-1:H]);
      hh_ff <= (2*HW)'(cabs_2_ff[CW-1:H]) * (2*HW)'(cabs_2_ff[CW-1:H]);
   end

   // stage 4: cross squared
   logic v4_ff, perp4_ff;
   logic [CW-1:0] len2_4_ff, nend_4_ff;
   logic [NW-1:0] c2_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      perp4_ff  <= perp3_ff;
      len2_4_ff <= len2_3_ff;
      nend_4_ff <= nend_3_ff;
      c2_ff <= (NW'(hh_ff) << (2 * H)) + (NW'(lh_ff) << (H + 1)) + NW'(ll_ff);
   end

   // divide chain; quotient stays below 2^K, so the top bits seed the remainder
   logic          dv   [0:K];
   logic [CW-1:0] drem [0:K];
   logic [CW-1:0] dacc [0:K];
   logic [CW-1:0] dlen [0:K];
   logic [CW-1:0] dnend[0:K];
   logic          dperp[0:K];

   assign dv[0]    = v4_ff;
   assign drem[0]  = c2_ff[NW-1:K];
   assign dacc[0]  = c2_ff[K-1:0];
   assign dlen[0]  = len2_4_ff;
   assign dnend[0] = nend_4_ff;
   assign dperp[0] = perp4_ff;

   for (genvar i = 0; i < K; i++) begin : g_div
      psd_div_cell #(.CW(CW)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .valid_i (dv[i]),
         .rem_i   (drem[i]),
         .acc_i   (dacc[i]),
         .len2_i  (dlen[i]),
         .nend_i  (dnend[i]),
         .perp_i  (dperp[i]),
         .valid_o (dv[i+1]),
         .rem_o   (drem[i+1]),
         .acc_o   (dacc[i+1]),
         .len2_o  (dlen[i+1]),
         .nend_o  (dnend[i+1]),
         .perp_o  (dperp[i+1])
      );
   end

   // select radicand
   logic vs_ff;
   logic [RW-1:0] rad_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         vs_ff <= 1'b0;
      end else begin
         vs_ff <= dv[K];
      end
      rad_ff <= dperp[K] ? RW'(dacc[K]) : RW'(dnend[K]);
   end

   // square root chain, msb first
   logic          sv   [0:R];
   logic [RW-1:0] srem [0:R];
   logic [R-1:0]  sroot[0:R];

   assign sv[0]    = vs_ff;
   assign srem[0]  = rad_ff;
   assign sroot[0] = '0;

   for (genvar j = 0; j < R; j++) begin : g_sqrt
      psd_sqrt_cell #(.RW(RW), .R(R), .BIT(R - 1 - j)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .valid_i (sv[j]),
         .rem_i   (srem[j]),
         .root_i  (sroot[j]),
         .valid_o (sv[j+1]),
         .rem_o   (srem[j+1]),
         .root_o  (sroot[j+1])
      );
   end

   // saturate and compare
   logic [MW-1:0] dist_wide;
   logic [psd_pkg::DIST_BITS-1:0] dist_sat;
   always_comb begin
      dist_wide = MW'(sroot[R]);
      dist_sat = (dist_wide > MW'(psd_pkg::DIST_MAX)) ? psd_pkg::DIST_MAX
                                                       : dist_wide[psd_pkg::DIST_BITS-1:0];
   end

   logic rv_ff, hit_ff;
   logic [psd_pkg::DIST_BITS-1:0] dist_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else begin
         rv_ff <= sv[R];
      end
      dist_ff <= dist_sat;
      hit_ff  <= dist_sat < psd_pkg::DIST_BITS'(thresh_ff);
   end

   assign rsp_valid    = rv_ff;
   assign rsp_distance = dist_ff;
   assign rsp_hit      = hit_ff;

   `PSD_ASSERT_DELAY(a_latency, clock, reset, accept, LAT, rsp_valid)
   `PSD_ASSERT_IMPL(a_hit_below, clock, reset, rsp_valid && rsp_hit,
      rsp_distance < psd_pkg::DIST_BITS'(thresh_ff))
   `PSD_ASSERT_IMPL(a_zero_thresh, clock, reset, rsp_valid && thresh_ff == '0, !rsp_hit)
endmodule
`default_nettype wire

// ===== verif/point_segment_distance_hit_test_tb.sv =====
// ---------------------------------------------------------------------------
// point_segment_distance_hit_test_tb
// Self-checking bench for the point to segment distance hit test.
// A local integer model predicts distance and hit for every accepted query.
// Directed corner queries run first, then random and near-segment traffic
// under several thresholds. The sender idles in bursts.
// ---------------------------------------------------------------------------
`default_nettype none
module point_segment_distance_hit_test_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CB          = psd_pkg::COORD_BITS_DEF;
   localparam int LATENCY     = 3 * CB + 9;
   localparam int STALL_LIMIT = 5000;
   localparam int CMIN        = -(1 << (CB - 1));
   localparam int CMAX        = (1 << (CB - 1)) - 1;

   typedef struct packed {
      logic [psd_pkg::DIST_BITS-1:0] distance;
      logic                          hit;
   } hit_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [CB-1:0] req_point_x = '0, req_point_y = '0;
   logic signed [CB-1:0] req_seg_ax = '0, req_seg_ay = '0;
   logic signed [CB-1:0] req_seg_bx = '0, req_seg_by = '0;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [psd_pkg::THRESH_BITS-1:0] csr_data = '0;
   logic rsp_valid;
   logic [psd_pkg::DIST_BITS-1:0] rsp_distance;
   logic rsp_hit;

   logic [psd_pkg::THRESH_BITS-1:0] threshold_copy;
   hit_result_type pending_hits[$];
   int mismatch_count = 0;
   int query_count = 0;
   int result_count = 0;
   int hit_count = 0;
   int idle_cycles = 0;
   int burst_left = 0;

   point_segment_distance_hit_test #(.COORD_BITS(CB)) uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_point_x(req_point_x), .req_point_y(req_point_y),
      .req_seg_ax(req_seg_ax), .req_seg_ay(req_seg_ay),
      .req_seg_bx(req_seg_bx), .req_seg_by(req_seg_by),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .rsp_valid(rsp_valid), .rsp_distance(rsp_distance), .rsp_hit(rsp_hit)
   );

   always #5 clock = ~clock;

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint unsigned floor_norm(longint x, longint y);
      return int_sqrt(x * x + y * y);
   endfunction

   function automatic hit_result_type predict_hit(longint px, longint py, longint ax,
                                                  longint ay, longint bx, longint by);
      longint dx, dy, rx, ry, dot, len2, cross_p;
      longint unsigned dist_calc, across;
      hit_result_type res;
      dx = bx - ax;
      dy = by - ay;
      rx = px - ax;
      ry = py - ay;
      dot = rx * dx + ry * dy;
      len2 = dx * dx + dy * dy;
      if (len2 == 0 || dot < 0) begin
         dist_calc = floor_norm(rx, ry);
      end else if (dot > len2) begin
         dist_calc = floor_norm(px - bx, py - by);
      end else begin
         cross_p = rx * dy - ry * dx;
         across = (cross_p < 0) ? -cross_p : cross_p;
         dist_calc = int_sqrt((across * across) / len2);
      end
      if (dist_calc > psd_pkg::DIST_MAX) dist_calc = psd_pkg::DIST_MAX;
      res.distance = dist_calc[psd_pkg::DIST_BITS-1:0];
      res.hit = (dist_calc < threshold_copy);
      return res;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      mismatch_count++;
      $display("mismatch on %s: got %0d expected %0d (result %0d)",
               what, got, want, result_count);
   endtask

   // response beats cannot be stalled; check every one as it goes by
   always @(posedge clock) begin
      hit_result_type want;
      if (!reset && rsp_valid) begin
         result_count++;
         if (pending_hits.size() == 0) begin
            report_mismatch("unexpected beat", longint'(rsp_distance), -1);
         end else begin
            want = pending_hits.pop_front();
            if (rsp_distance !== want.distance)
               report_mismatch("distance", longint'(rsp_distance), longint'(want.distance));
            if (rsp_hit !== want.hit)
               report_mismatch("hit", longint'(rsp_hit), longint'(want.hit));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   task automatic send_query(int px, int py, int ax, int ay, int bx, int by);
      hit_result_type want;
      // bursts of back to back beats with random gaps between them
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 3) != 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
      burst_left--;
      start <= 1'b1;
      req_point_x <= CB'(px);
      req_point_y <= CB'(py);
      req_seg_ax <= CB'(ax);
      req_seg_ay <= CB'(ay);
      req_seg_bx <= CB'(bx);
      req_seg_by <= CB'(by);
      do @(posedge clock); while (busy);
      want = predict_hit(px, py, ax, ay, bx, by);
      pending_hits.push_back(want);
      query_count++;
      if (want.hit) hit_count++;
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic write_threshold(logic [psd_pkg::THRESH_BITS-1:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      threshold_copy = value;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic int rand_coord();
      return $urandom_range(0, CMAX - CMIN) + CMIN;
   endfunction

   function automatic int near_coord(int center, int spread);
      int v;
      v = center + $urandom_range(0, 2 * spread) - spread;
      if (v > CMAX) v = CMAX;
      if (v < CMIN) v = CMIN;
      return v;
   endfunction

   task automatic test_directed();
      // reset threshold is in force on the first call; the second call runs at 255
      send_query(0, 0, 0, 0, 0, 0);
      send_query(1, 1, 0, 0, 0, 0);
      send_query(CMAX, CMAX, CMIN, CMIN, CMIN, CMIN);
      send_query(CMIN, CMIN, CMAX, CMAX, CMAX, CMAX);
      send_query(CMIN, CMAX, CMAX, CMIN, CMAX, CMIN);
      send_query(CMAX, CMIN, CMIN, CMAX, CMAX, CMIN);
      send_query(0, 0, CMIN, CMIN, CMAX, CMAX);
      send_query(CMIN, CMAX, CMIN, CMIN, CMAX, CMAX);
      send_query(-5, 0, 0, 0, 10, 0);
      send_query(15, 3, 0, 0, 10, 0);
      send_query(0, 7, 0, 0, 10, 0);
      send_query(10, 7, 0, 0, 10, 0);
      send_query(4, 2, 0, 0, 10, 0);
      send_query(5, 1, 0, 0, 10, 10);
      send_query(3, 3, 0, 0, 10, 10);
      send_query(7, -2, 3, -6, 3, -6);
      send_query(CMAX, 0, CMIN, 0, CMAX, 0);
      send_query(-1, -1, -1, -1, -2, -2);
      send_query(0, CMIN, 0, CMIN, 0, CMAX);
      send_query(2, 2, 0, 0, 0, 4);
   endtask

   task automatic test_random(int count);
      int kind, ax, ay, bx, by, px, py, span;
      for (int i = 0; i < count; i++) begin
         kind = $urandom_range(0, 9);
         span = ($urandom_range(0, 3) == 0) ? 8000 : $urandom_range(1, 60);
         ax = rand_coord();
         ay = rand_coord();
         bx = near_coord(ax, span);
         by = near_coord(ay, span);
         case (kind)
            0, 1: begin
               send_query(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                          rand_coord(), rand_coord());
            end
            2: begin
               send_query(near_coord(ax, 20), near_coord(ay, 20), ax, ay, ax, ay);
            end
            3: begin
               // point close to one endpoint
               send_query(near_coord(bx, 8), near_coord(by, 8), ax, ay, bx, by);
            end
            default: begin
               // point near the segment's interior
               px = (ax + bx) / 2;
               py = (ay + by) / 2;
               send_query(near_coord(px, span / 2 + 4), near_coord(py, span / 2 + 4),
                          ax, ay, bx, by);
            end
         endcase
      end
   endtask

   initial begin
      threshold_copy = psd_pkg::THRESH_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(150);
      write_threshold(8'd0);
      test_random(250);
      write_threshold(8'd255);
      test_directed();
      test_random(300);
      write_threshold(8'($urandom_range(1, 254)));
      test_random(300);
      write_threshold(8'd1);
      test_random(150);
      write_threshold(8'd128);
      test_random(250);
      wait_drained();
      $display("ran %0d queries, %0d results, %0d hits, thresholds 0 to 255",
               query_count, result_count, hit_count);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
